// File: hdl/cphd_pkg.sv
`default_nettype none
package cphd_pkg;

   // Field widths
   localparam int unsigned VoltW  = 16;
   localparam int unsigned TickW  = 16;
   localparam int unsigned OffW   = 16;
   localparam int unsigned ActW   = 2;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrDataW = 16;

   // Action codes
   localparam logic [ActW-1:0] ACT_TICK = 2'd0;
   localparam logic [ActW-1:0] ACT_ON   = 2'd1;
   localparam logic [ActW-1:0] ACT_OFF  = 2'd2;

   // Register indexes
   localparam logic [CsrIdxW-1:0] REG_PULLIN_VOLTAGE = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_HOLD_VOLTAGE   = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_PULLIN_TICKS   = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_UPDATE_TICKS   = 2'd3;

   // Register reset values
   localparam logic [TickW-1:0] PULLIN_TICKS_RST = 16'd20;
   localparam logic [TickW-1:0] UPDATE_TICKS_RST = 16'd211;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_RESPOND
   } ctl_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic accept;
      logic div_step;
      logic div_last;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic needs_div;
   } dp_status_type;

endpackage
`default_nettype wire

// File: hdl/cphd_intf.sv
`default_nettype none
interface cphd_req_if
   import cphd_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ActW-1:0]  action;
   logic [VoltW-1:0] supply_voltage;

   modport source (output valid, output action, output supply_voltage, input ready);
   modport sink   (input valid, input action, input supply_voltage, output ready);
endinterface

interface cphd_rsp_if
   import cphd_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [OffW-1:0] off_time;
   logic            output_on;
   logic            in_pullin;
   logic            duty_updated;

   modport source (output valid, output off_time, output output_on, output in_pullin,
                   output duty_updated, input ready);
   modport sink   (input valid, input off_time, input output_on, input in_pullin,
                   input duty_updated, output ready);
endinterface
`default_nettype wire

// File: hdl/coil_pullin_hold_pwm_driver.sv
`default_nettype none
// Relay coil PWM driver with pull-in and hold phases and supply compensation.
// Each request transaction carries a tick, on or off action and the measured
// supply; each yields exactly one response transaction with the off-time and
// the coil status. One transaction is handled at a time: an action that needs
// no duty recomputation returns its response in the cycle after acceptance;
// one that recomputes the duty with the supply above the target first steps
// the shared restoring divider through every duty bit, then responds, and the
// controller returns to idle after the response is taken. Register writes
// through the csr port take effect at the next load or recomputation.
module coil_pullin_hold_pwm_driver
   import cphd_pkg::*;
#(
   parameter int unsigned DUTY_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   cphd_req_if.sink                 req_chan,
   cphd_rsp_if.source               rsp_chan,
   input  wire logic                csr_write,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencer
   cphd_ctrl #(
      .DUTY_BITS (DUTY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // State, registers and divider
   cphd_datapath #(
      .DUTY_BITS (DUTY_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .action         (req_chan.action),
      .supply_voltage (req_chan.supply_voltage),
      .cmd            (cmd),
      .status         (status),
      .off_time       (rsp_chan.off_time),
      .output_on      (rsp_chan.output_on),
      .in_pullin      (rsp_chan.in_pullin),
      .duty_updated   (rsp_chan.duty_updated)
   );

endmodule
`default_nettype wire

// File: hdl/cphd_ctrl.sv
`default_nettype none
module cphd_ctrl
   import cphd_pkg::*;
#(
   parameter int unsigned DUTY_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   localparam int unsigned CntW = $clog2(DUTY_BITS);
   localparam logic [CntW-1:0] LastStep = CntW'(DUTY_BITS - 1);

   ctl_state_type   state_ff, state_in;
   logic [CntW-1:0] step_ff, step_in;

   // State and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = status.needs_div ? ST_DIVIDE : ST_RESPOND;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == LastStep) begin
               cmd.div_last = 1'b1;
               state_in     = ST_RESPOND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/cphd_datapath.sv
`default_nettype none
module cphd_datapath
   import cphd_pkg::*;
#(
   parameter int unsigned DUTY_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_data,
   input  wire logic [ActW-1:0]     action,
   input  wire logic [VoltW-1:0]    supply_voltage,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   output logic [OffW-1:0]          off_time,
   output logic                     output_on,
   output logic                     in_pullin,
   output logic                     duty_updated
);

   // Configuration registers
   logic [VoltW-1:0] pullin_voltage_ff, hold_voltage_ff;
   logic [TickW-1:0] pullin_ticks_ff, update_ticks_ff;

   // Coil state
   logic             enabled_ff, pullin_ff, updated_ff;
   logic [TickW-1:0] ticks_left_ff;
   logic [OffW-1:0]  off_time_ff;

   // Divider
   logic [VoltW-1:0]     rem_ff, div_ff;
   logic [DUTY_BITS-1:0] quo_ff;

   logic             is_on, is_off, is_tick, expire, compute;
   logic [VoltW-1:0] target;
   logic [VoltW:0]   shifted, diff;
   logic             q_bit;
   logic [VoltW-1:0] rem_in;
   logic [DUTY_BITS-1:0] quo_in, duty, off_duty;
   logic [OffW-1:0]  off_new;

   // Decode the transaction against the current state
   always_comb begin
      is_on   = (action == ACT_ON);
      is_off  = (action == ACT_OFF);
      is_tick = (action == ACT_TICK) && enabled_ff;
      expire  = is_tick && (ticks_left_ff <= TickW'(1));
      compute = is_on || expire;
      target  = is_on ? pullin_voltage_ff : hold_voltage_ff;
      status.needs_div = compute && (supply_voltage > target);
   end

   // One restoring division step; duty = q*FS >> D reduces to q-1 for q>0
   always_comb begin
      shifted  = {rem_ff, 1'b0};
      diff     = shifted - {1'b0, div_ff};
      q_bit    = (shifted >= {1'b0, div_ff});
      rem_in   = q_bit ? diff[VoltW-1:0] : shifted[VoltW-1:0];
      quo_in   = {quo_ff[DUTY_BITS-2:0], q_bit};
      duty     = (quo_in == '0) ? '0 : quo_in - 1'b1;
      off_duty = ~duty;
      off_new  = OffW'(off_duty);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pullin_voltage_ff <= '0;
         hold_voltage_ff   <= '0;
         pullin_ticks_ff   <= PULLIN_TICKS_RST;
         update_ticks_ff   <= UPDATE_TICKS_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PULLIN_VOLTAGE: pullin_voltage_ff <= csr_data;
            REG_HOLD_VOLTAGE:   hold_voltage_ff   <= csr_data;
            REG_PULLIN_TICKS:   pullin_ticks_ff   <= csr_data;
            REG_UPDATE_TICKS:   update_ticks_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Coil state update
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         pullin_ff     <= 1'b1;
         updated_ff    <= 1'b0;
         ticks_left_ff <= '0;
         off_time_ff   <= '0;
      end else if (cmd.accept) begin
         updated_ff <= compute;
         if (is_on) begin
            enabled_ff    <= 1'b1;
            pullin_ff     <= 1'b1;
            ticks_left_ff <= pullin_ticks_ff;
         end
         if (is_off) begin
            enabled_ff <= 1'b0;
         end
         if (expire) begin
            pullin_ff     <= 1'b0;
            ticks_left_ff <= update_ticks_ff;
         end else if (is_tick) begin
            ticks_left_ff <= ticks_left_ff - 1'b1;
         end
         // supply at or below target: full duty, zero off-time
         if (compute && !status.needs_div) begin
            off_time_ff <= '0;
         end
      end else if (cmd.div_last) begin
         off_time_ff <= off_new;
      end
   end

   // Divider registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rem_ff <= target;
         div_ff <= supply_voltage;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign off_time     = off_time_ff;
   assign output_on    = enabled_ff;
   assign in_pullin    = pullin_ff;
   assign duty_updated = updated_ff;

endmodule
`default_nettype wire
